// ===== sv/assert_macros.svh =====
// Assertion macros included by the sponge RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every rising clock edge outside reset.
`define KP_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// An implication checked in the same cycle.
`define KP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

// ===== sv/kp800_pkg.sv =====
// Types, constants and round function of the Keccak-p[800] sponge.
package kp800_pkg;

    localparam int LANE_COUNT     = 25;
    localparam int MAX_ROUNDS     = 40;
    localparam int DEFAULT_ROUNDS = 20;
    localparam int STATE_BYTES    = 100;
    localparam int MAX_DIGEST     = 49;

    typedef logic [31:0] t_lane;
    typedef logic [LANE_COUNT-1:0][31:0] t_state;
    typedef logic [1:0] t_func;

    localparam t_func FUNC_ABSORB  = 2'd0;
    localparam t_func FUNC_SQUEEZE = 2'd1;
    localparam t_func FUNC_RESTART = 2'd2;

    localparam logic CFG_ROUND_COUNT   = 1'b0;
    localparam logic CFG_DIGEST_LENGTH = 1'b1;

    localparam logic [7:0] PAD_FIRST = 8'h01;
    localparam logic [7:0] PAD_LAST  = 8'h80;

    localparam int RHO [LANE_COUNT] = '{
        0, 1, 30, 28, 27,
        4, 12, 6, 23, 20,
        3, 10, 11, 25, 7,
        9, 13, 15, 21, 8,
        18, 2, 29, 24, 14
    };

    function automatic t_lane round_const(input logic [5:0] r);
        t_lane rc;
        unique case (r)
            6'd0:  rc = 32'h00000001;
            6'd1:  rc = 32'h00008082;
            6'd2:  rc = 32'h8000808A;
            6'd3:  rc = 32'h00008000;
            6'd4:  rc = 32'h0000808B;
            6'd5:  rc = 32'h80000001;
            6'd6:  rc = 32'h00008081;
            6'd7:  rc = 32'h80008009;
            6'd8:  rc = 32'h0000008A;
            6'd9:  rc = 32'h00000088;
            6'd10: rc = 32'h80008009;
            6'd11: rc = 32'h8000000A;
            6'd12: rc = 32'h8000808B;
            6'd13: rc = 32'h8000008B;
            6'd14: rc = 32'h80008089;
            6'd15: rc = 32'h80008003;
            6'd16: rc = 32'h80008002;
            6'd17: rc = 32'h80000080;
            6'd18: rc = 32'h0000800A;
            6'd19: rc = 32'h0000000A;
            6'd20: rc = 32'h00008081;
            6'd21: rc = 32'h80008080;
            6'd22: rc = 32'h80000001;
            6'd23: rc = 32'h00008008;
            6'd24: rc = 32'h00008082;
            6'd25: rc = 32'h0000800A;
            6'd26: rc = 32'h80000003;
            6'd27: rc = 32'h00000009;
            6'd28: rc = 32'h80008082;
            6'd29: rc = 32'h00008009;
            6'd30: rc = 32'h80000080;
            6'd31: rc = 32'h00008083;
            6'd32: rc = 32'h80000081;
            6'd33: rc = 32'h00000001;
            6'd34: rc = 32'h0000800B;
            6'd35: rc = 32'h00008001;
            6'd36: rc = 32'h00000080;
            6'd37: rc = 32'h80008000;
            6'd38: rc = 32'h00008001;
            6'd39: rc = 32'h00000009;
            default: rc = '0;
        endcase
        return rc;
    endfunction

    function automatic t_lane rotl(input t_lane v, input int n);
        logic [63:0] t;
        t = {v, v} << n;
        return t[63:32];
    endfunction

    // One full round: theta, rho, pi, chi and iota.
    function automatic t_state keccak_round(input t_state s, input t_lane rc);
        t_lane  c [5];
        t_lane  d [5];
        t_state a;
        t_state b;
        for (int x = 0; x < 5; x++) begin
            c[x] = s[x] ^ s[x+5] ^ s[x+10] ^ s[x+15] ^ s[x+20];
        end
        for (int x = 0; x < 5; x++) begin
            d[x] = c[(x+4)%5] ^ rotl(c[(x+1)%5], 1);
        end
        for (int i = 0; i < LANE_COUNT; i++) begin
            a[i] = s[i] ^ d[i%5];
        end
        for (int y = 0; y < 5; y++) begin
            for (int x = 0; x < 5; x++) begin
                b[y + 5*((2*x + 3*y) % 5)] = rotl(a[x + 5*y], RHO[x + 5*y]);
            end
        end
        for (int y = 0; y < 5; y++) begin
            for (int x = 0; x < 5; x++) begin
                a[x + 5*y] = b[x + 5*y] ^ (~b[(x+1)%5 + 5*y] & b[(x+2)%5 + 5*y]);
            end
        end
        a[0] = a[0] ^ rc;
        return a;
    endfunction

endpackage

// ===== sv/kp800_in_if.sv =====
// Input channel of the sponge: operation code and message byte.
interface kp800_in_if;
    logic                  valid;
    logic                  ready;
    kp800_pkg::t_func      func;
    logic [7:0]            data_byte;

    modport source (output valid, output func, output data_byte, input ready);
    modport sink   (input valid, input func, input data_byte, output ready);
endinterface

// ===== sv/kp800_out_if.sv =====
// Output channel of the sponge: squeezed digest byte.
interface kp800_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;

    modport source (output valid, output out_byte, input ready);
    modport sink   (input valid, input out_byte, output ready);
endinterface

// ===== sv/keccak_p800_sponge_hash.sv =====
// An absorb or restart takes effect in the next cycle; a squeeze inside the rate gives a
// registered byte. At the rate boundary the shared round unit permutes, one round per cycle
// (20 rounds by default); a squeeze there gives its byte from the emit step after the last
// round. The first squeeze pads in the idle and pad steps, permutes, then emits. Throughput:
// one absorb or squeeze per cycle between permutations; not ready while padding, permuting or
// holding a byte for a stalled receiver. Reset is synchronous, active low.
module keccak_p800_sponge_hash (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    kp800_in_if.sink             i_in,
    kp800_out_if.source          o_out,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_index,
    input  logic [5:0]           i_cfg_wdata
);

    // Reset clears the state, returns to absorbing at position 0, selects 20 rounds and 32 bytes.

    `include "assert_macros.svh"

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_PAD  = 2'd1;
    localparam logic [1:0] ST_PERM = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]          r_state, n_state;
    kp800_pkg::t_state   r_lanes, n_lanes;
    logic [6:0]          r_pos, n_pos;
    logic                r_squeezing, n_squeezing;
    logic [5:0]          r_round, n_round;
    logic                r_emit_after, n_emit_after;
    logic [5:0]          r_round_count;
    logic [5:0]          r_digest_len;
    logic                r_out_valid, n_out_valid;
    logic [7:0]          r_out_byte, n_out_byte;

    logic                accept;
    logic                out_free;
    logic [5:0]          len_clamped;
    logic [6:0]          rate;
    logic [5:0]          rounds_total;
    logic [5:0]          rounds_last;
    logic [6:0]          abs_pos;
    logic [6:0]          abs_next;
    logic [6:0]          acc_pos;
    logic [31:0]         sel_lane;
    logic [31:0]         shifted;
    logic [7:0]          rd_byte;

    assign i_in.ready     = (r_state == ST_IDLE);
    assign accept         = i_in.valid && i_in.ready;
    assign out_free       = !r_out_valid || o_out.ready;
    assign o_out.valid    = r_out_valid;
    assign o_out.out_byte = r_out_byte;

    always_comb begin
        if (r_digest_len == 6'd0) begin
            len_clamped = 6'd1;
        end else if (r_digest_len > 6'(kp800_pkg::MAX_DIGEST)) begin
            len_clamped = 6'(kp800_pkg::MAX_DIGEST);
        end else begin
            len_clamped = r_digest_len;
        end
        if (r_round_count == 6'd0) begin
            rounds_total = 6'(kp800_pkg::DEFAULT_ROUNDS);
        end else if (r_round_count > 6'(kp800_pkg::MAX_ROUNDS)) begin
            rounds_total = 6'(kp800_pkg::MAX_ROUNDS);
        end else begin
            rounds_total = r_round_count;
        end
    end

    assign rate        = 7'(kp800_pkg::STATE_BYTES) - {len_clamped, 1'b0};
    assign rounds_last = rounds_total - 6'd1;
    assign abs_pos     = r_squeezing ? 7'd0 : r_pos;
    assign abs_next    = abs_pos + 7'd1;

    // Single byte port into the lane file: position picks lane and byte lane.
    always_comb begin
        priority if (r_state == ST_PAD) begin
            acc_pos = rate - 7'd1;
        end else if (r_state == ST_IDLE && i_in.func == kp800_pkg::FUNC_ABSORB) begin
            acc_pos = abs_pos;
        end else begin
            acc_pos = r_pos;
        end
    end

    assign sel_lane = r_lanes[acc_pos[6:2]];
    assign shifted  = sel_lane >> {acc_pos[1:0], 3'b000};
    assign rd_byte  = shifted[7:0];

    always_comb begin
        n_state      = r_state;
        n_lanes      = r_lanes;
        n_pos        = r_pos;
        n_squeezing  = r_squeezing;
        n_round      = r_round;
        n_emit_after = r_emit_after;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_byte   = r_out_byte;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    unique case (i_in.func)
                        kp800_pkg::FUNC_RESTART: begin
                            n_lanes     = '0;
                            n_pos       = 7'd0;
                            n_squeezing = 1'b0;
                        end
                        kp800_pkg::FUNC_ABSORB: begin
                            n_lanes[acc_pos[6:2]] = sel_lane
                                ^ ({24'd0, i_in.data_byte} << {acc_pos[1:0], 3'b000});
                            n_squeezing = 1'b0;
                            if (abs_next >= rate) begin
                                n_pos        = 7'd0;
                                n_state      = ST_PERM;
                                n_round      = 6'd0;
                                n_emit_after = 1'b0;
                            end else begin
                                n_pos = abs_next;
                            end
                        end
                        kp800_pkg::FUNC_SQUEEZE: begin
                            if (!r_squeezing) begin
                                n_lanes[acc_pos[6:2]] = sel_lane
                                    ^ ({24'd0, kp800_pkg::PAD_FIRST} << {acc_pos[1:0], 3'b000});
                                n_state = ST_PAD;
                            end else if (r_pos >= rate) begin
                                n_pos        = 7'd0;
                                n_state      = ST_PERM;
                                n_round      = 6'd0;
                                n_emit_after = 1'b1;
                            end else if (out_free) begin
                                n_out_valid = 1'b1;
                                n_out_byte  = rd_byte;
                                n_pos       = r_pos + 7'd1;
                            end else begin
                                n_state = ST_EMIT;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_PAD: begin
                n_lanes[acc_pos[6:2]] = sel_lane
                    ^ ({24'd0, kp800_pkg::PAD_LAST} << {acc_pos[1:0], 3'b000});
                n_squeezing  = 1'b1;
                n_pos        = 7'd0;
                n_state      = ST_PERM;
                n_round      = 6'd0;
                n_emit_after = 1'b1;
            end
            ST_PERM: begin
                n_lanes = kp800_pkg::keccak_round(r_lanes, kp800_pkg::round_const(r_round));
                if (r_round == rounds_last) begin
                    n_state = r_emit_after ? ST_EMIT : ST_IDLE;
                end else begin
                    n_round = r_round + 6'd1;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = rd_byte;
                    n_pos       = r_pos + 7'd1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_lanes       <= '0;
            r_pos         <= 7'd0;
            r_squeezing   <= 1'b0;
            r_round       <= 6'd0;
            r_emit_after  <= 1'b0;
            r_round_count <= 6'd0;
            r_digest_len  <= 6'd32;
            r_out_valid   <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_lanes      <= n_lanes;
            r_pos        <= n_pos;
            r_squeezing  <= n_squeezing;
            r_round      <= n_round;
            r_emit_after <= n_emit_after;
            r_out_valid  <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    kp800_pkg::CFG_ROUND_COUNT:   r_round_count <= i_cfg_wdata;
                    kp800_pkg::CFG_DIGEST_LENGTH: r_digest_len  <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_byte <= n_out_byte;
    end

    `KP_ASSERT(a_pos_in_state, i_clk, i_rst_n, r_pos <= 7'd98)
    `KP_ASSERT_IMP(a_round_in_range, i_clk, i_rst_n, r_state == ST_PERM, r_round <= rounds_last)
    `KP_ASSERT_IMP(a_emit_when_squeezing, i_clk, i_rst_n, r_state == ST_EMIT, r_squeezing)

endmodule
